FILE: src/pbba_pkg.sv
package pbba_pkg;

    // Bitmap geometry: 32 words of 32 bits, 1024 blocks at most.
    localparam int MAP_WORDS = 32;
    localparam int WORD_BITS = 32;
    localparam int MAP_BITS  = MAP_WORDS * WORD_BITS;
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIDX_W    = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(MAP_BITS + 1);

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd2;

    // Configuration register indexes.
    localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic REG_PAGE_BASE       = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] block_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
    } t_resp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MOD
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic look;
        logic commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_stall;
    } t_stat;

endpackage

FILE: src/pbba_ram.sv
module pbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/pbba_ctrl.sv
module pbba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pbba_pkg::t_stat i_stat,
    output pbba_pkg::t_cmd  o_cmd
);

    pbba_pkg::t_state r_state;
    pbba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            pbba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pbba_pkg::S_LOOK;
                end
            end
            pbba_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = pbba_pkg::S_MOD;
            end
            pbba_pkg::S_MOD: begin
                // hold until the output register can take the response
                if (!i_stat.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pbba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/pbba_dp.sv
module pbba_dp #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    input  pbba_pkg::t_req  i_req,
    input  pbba_pkg::t_cmd  i_cmd,
    output pbba_pkg::t_stat o_stat,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output pbba_pkg::t_resp o_resp
);

    localparam int WW = pbba_pkg::WIDX_W;
    localparam int BW = pbba_pkg::BIDX_W;
    localparam int CW = pbba_pkg::CNT_W;

    typedef struct packed {
        logic          found;
        logic [BW-1:0] pos;
    } t_find;

    // lowest set bit of a map word
    function automatic t_find first_one(input logic [pbba_pkg::WORD_BITS-1:0] v);
        t_find f;
        f = '0;
        for (int i = pbba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                f.found = 1'b1;
                f.pos   = BW'(i);
            end
        end
        return f;
    endfunction

    // configuration
    logic [3:0]  r_bsl2;
    logic [31:0] r_base;

    // request and lookup
    logic          r_op;
    logic [31:0]   r_addr;
    logic [WW-1:0] r_word;
    logic [BW-1:0] r_bit;
    logic          r_err;
    logic          r_none;

    // map summary and per-word valid bits
    logic [pbba_pkg::MAP_WORDS-1:0] r_full;
    logic [pbba_pkg::MAP_WORDS-1:0] r_wvalid;

    logic            r_out_valid;
    pbba_pkg::t_resp r_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl2 <= 4'd2;
            r_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbba_pkg::REG_BLOCK_SIZE_LOG2: r_bsl2 <= i_cfg_data[3:0];
                pbba_pkg::REG_PAGE_BASE:       r_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block count: PAGE_BYTES >> log2 size, clamped to 1 .. MAP_BITS
    logic [31:0]   cnt_raw;
    logic [CW-1:0] blk_cnt;

    always_comb begin
        cnt_raw = 32'(PAGE_BYTES) >> r_bsl2;
        if (cnt_raw == '0) begin
            blk_cnt = CW'(1);
        end else if (cnt_raw > 32'(pbba_pkg::MAP_BITS)) begin
            blk_cnt = CW'(pbba_pkg::MAP_BITS);
        end else begin
            blk_cnt = cnt_raw[CW-1:0];
        end
    end

    // lookup stage: pick the map word
    logic [31:0]   offset;
    logic [31:0]   align_mask;
    logic [31:0]   free_idx;
    logic          free_bad;
    t_find         sum_find;
    logic [WW-1:0] look_word;

    always_comb begin
        offset     = r_addr - r_base;
        align_mask = ~(32'hffff_ffff << r_bsl2);
        free_idx   = offset >> r_bsl2;
        free_bad   = ((offset & align_mask) != '0) || (free_idx >= 32'(blk_cnt));
        sum_find   = first_one(~r_full);
        look_word  = (r_op == pbba_pkg::OP_FREE) ? free_idx[WW+BW-1:BW] : sum_find.pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.op;
            r_addr <= i_req.block_address;
        end
        if (i_cmd.look) begin
            r_word <= look_word;
            r_bit  <= free_idx[BW-1:0];
            r_err  <= free_bad;
            r_none <= !sum_find.found;
        end
    end

    // map storage, read during lookup, written at commit
    logic [WW-1:0]                  ram_addr;
    logic [pbba_pkg::WORD_BITS-1:0] ram_q;
    logic [pbba_pkg::WORD_BITS-1:0] new_word;
    logic                           do_write;

    assign ram_addr = i_cmd.look ? look_word : r_word;

    pbba_ram #(
        .WIDTH (pbba_pkg::WORD_BITS),
        .DEPTH (pbba_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit & do_write),
        .i_addr  (ram_addr),
        .i_wdata (new_word),
        .o_rdata (ram_q)
    );

    // modify stage
    logic [pbba_pkg::WORD_BITS-1:0] word_q;
    logic [pbba_pkg::WORD_BITS-1:0] in_range;
    logic [CW-1-BW:0]               cnt_hi;
    logic [BW-1:0]                  cnt_lo;
    t_find                          bit_find;
    pbba_pkg::t_resp                mod_resp;

    always_comb begin
        word_q = r_wvalid[r_word] ? ram_q : '0;
        cnt_hi = blk_cnt[CW-1:BW];
        cnt_lo = blk_cnt[BW-1:0];
        if ((CW-BW)'(r_word) < cnt_hi) begin
            in_range = '1;
        end else if ((CW-BW)'(r_word) == cnt_hi) begin
            in_range = ~({pbba_pkg::WORD_BITS{1'b1}} << cnt_lo);
        end else begin
            in_range = '0;
        end
        bit_find = first_one(~word_q & in_range);

        new_word = word_q;
        do_write = 1'b0;
        mod_resp = '0;
        if (r_op == pbba_pkg::OP_ALLOC) begin
            if (r_none || !bit_find.found) begin
                mod_resp.status = pbba_pkg::STATUS_FULL;
            end else begin
                new_word = word_q | (pbba_pkg::WORD_BITS'(1) << bit_find.pos);
                do_write = 1'b1;
                mod_resp.status          = pbba_pkg::STATUS_OK;
                mod_resp.granted_address = r_base + (32'({r_word, bit_find.pos}) << r_bsl2);
            end
        end else begin
            if (r_err) begin
                mod_resp.status = pbba_pkg::STATUS_MISALIGNED;
            end else begin
                new_word = word_q & ~(pbba_pkg::WORD_BITS'(1) << r_bit);
                do_write = 1'b1;
                mod_resp.status = pbba_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= '0;
            r_wvalid <= '0;
        end else if (i_cmd.commit && do_write) begin
            r_full[r_word]   <= &new_word;
            r_wvalid[r_word] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_resp <= mod_resp;
        end
    end

    assign o_stat.out_stall = r_out_valid & ~i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_resp           = r_resp;

endmodule

FILE: src/page_bitmap_block_allocator_core.sv
// Block allocator for one page of PAGE_BYTES bytes split into equal blocks of
// 2^block_size_log2 bytes (block count = PAGE_BYTES >> log2 size, clamped to
// 1..1024). An allocate request takes the lowest free block and returns
// page_base + index * block size, or status full; a free request turns the
// address into a block index and clears it, or returns status misaligned when
// the offset is not a block start or lies beyond the page. Each request goes
// through accept, lookup and modify: the accepting cycle registers the request,
// the next picks the map word (a 32-bit full-word summary for allocate, offset
// arithmetic for free) and issues the registered read of that word from the
// map RAM, and the third, once the output register can take the response,
// modifies the word, writes back any change and loads the output register.
// The block returns to idle in the same cycle that the response becomes valid.
// A new request is taken only while the block is idle; a response waiting in
// the output register stalls the next commit, not the acceptance. The map is
// clear right after reset with no clearing pass. Write configuration only
// while no request is in flight.
module page_bitmap_block_allocator_core #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,

    // configuration write port
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [31:0]     i_cfg_data,

    // request channel
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pbba_pkg::t_req  i_in_data,

    // response channel
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pbba_pkg::t_resp o_out_data
);

    pbba_pkg::t_cmd  cmd;
    pbba_pkg::t_stat stat;

    // sequence each request: accept, look up, commit
    pbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold configuration, bitmap, summary and the response register
    pbba_dp #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_resp      (o_out_data)
    );

endmodule

FILE: tb/alloc_response_checker.sv
`timescale 1ns / 1ps
module alloc_response_checker #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [31:0]      i_cfg_data,

    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  pbba_pkg::t_req   i_in_data,

    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  pbba_pkg::t_resp  i_out_data,

    output int               o_fail_count,
    output int               o_pending
);

    // Shadow of the page: used-block map and the two registers.
    logic [31:0] used_map [pbba_pkg::MAP_WORDS];
    logic [3:0]  blk_log2;
    logic [31:0] base_addr;

    pbba_pkg::t_resp awaited_q [$];
    int              errors = 0;

    function automatic int unsigned blocks_in_page();
        int unsigned n;
        n = PAGE_BYTES >> blk_log2;
        if (n < 1) n = 1;
        if (n > pbba_pkg::MAP_BITS) n = pbba_pkg::MAP_BITS;
        return n;
    endfunction

    // Apply one request to the shadow map and return its response.
    function automatic pbba_pkg::t_resp predict_response(input pbba_pkg::t_req req);
        pbba_pkg::t_resp resp;
        int unsigned     n;
        int unsigned     i;
        logic [31:0]     offset;
        logic [31:0]     mask;
        logic [31:0]     idx;
        bit              found;
        n = blocks_in_page();
        resp.status = pbba_pkg::STATUS_OK;
        resp.granted_address = '0;
        if (req.op == pbba_pkg::OP_ALLOC) begin
            found = 1'b0;
            for (i = 0; i < n && !found; i++) begin
                if (!used_map[i / pbba_pkg::WORD_BITS][i % pbba_pkg::WORD_BITS]) begin
                    used_map[i / pbba_pkg::WORD_BITS][i % pbba_pkg::WORD_BITS] = 1'b1;
                    resp.granted_address = base_addr + (i << blk_log2);
                    found = 1'b1;
                end
            end
            if (!found) resp.status = pbba_pkg::STATUS_FULL;
        end else begin
            offset = req.block_address - base_addr;
            mask   = (32'd1 << blk_log2) - 32'd1;
            idx    = offset >> blk_log2;
            if ((offset & mask) != 0 || idx >= n) begin
                resp.status = pbba_pkg::STATUS_MISALIGNED;
            end else begin
                used_map[idx[9:5]][idx[4:0]] = 1'b0;
            end
        end
        return resp;
    endfunction

    always @(posedge i_clk) begin : watch
        pbba_pkg::t_resp want;
        int              w;
        if (!i_rst_n) begin
            for (w = 0; w < pbba_pkg::MAP_WORDS; w++) used_map[w] = '0;
            blk_log2  = 4'd2;
            base_addr = '0;
            awaited_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == pbba_pkg::REG_BLOCK_SIZE_LOG2) blk_log2 = i_cfg_data[3:0];
                else base_addr = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    $error("unexpected response: status %0d granted_address %h",
                           i_out_data.status, i_out_data.granted_address);
                    errors++;
                end else begin
                    want = awaited_q.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                        errors++;
                    end
                    if (i_out_data.granted_address !== want.granted_address) begin
                        $error("granted_address: expected %h, got %h",
                               want.granted_address, i_out_data.granted_address);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) awaited_q.push_back(predict_response(i_in_data));
        end
        o_pending    <= awaited_q.size();
        o_fail_count <= errors;
    end

endmodule

FILE: tb/tb_page_bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
module tb_page_bitmap_block_allocator_core;

    localparam int PAGE_BYTES    = 4096;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 12;
    localparam int LONG_HOLD     = 300;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic            i_cfg_index;
    logic [31:0]     i_cfg_data;
    logic            i_in_valid;
    logic            o_in_ready;
    pbba_pkg::t_req  i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    pbba_pkg::t_resp o_out_data;

    int fail_count;
    int pending;
    int cycles    = 0;
    // Bumped by the request side to ask the response side for one long hold-off.
    int hold_asks = 0;

    page_bitmap_block_allocator_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    alloc_response_checker #(
        .PAGE_BYTES (PAGE_BYTES)
    ) alloc_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned page_blocks(input logic [3:0] log2);
        int unsigned n;
        n = PAGE_BYTES >> log2;
        if (n < 1) n = 1;
        if (n > pbba_pkg::MAP_BITS) n = pbba_pkg::MAP_BITS;
        return n;
    endfunction

    // Free addresses: mostly real block starts near the low end of the page
    // (where allocation lands), plus blocks past the end, offsets inside a
    // block and plain noise.
    function automatic logic [31:0] pick_free_address(input logic [3:0] log2,
                                                      input logic [31:0] base);
        int unsigned n;
        int unsigned idx;
        int          r;
        n   = page_blocks(log2);
        r   = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) != 0 && n > 48) ? $urandom_range(0, 47)
                                                    : $urandom_range(0, n - 1);
        if (r < 70) return base + (idx << log2);
        if (r < 80) return base + ((n + $urandom_range(0, 7)) << log2);
        if (r < 90 && log2 != 0) return base + (idx << log2) + $urandom_range(1, (1 << log2) - 1);
        return $urandom();
    endfunction

    // Offer one request after an optional gap; return at the edge it is taken.
    // Valid stays high on return so back-to-back requests never drop it.
    task automatic offer(input logic op, input logic [31:0] addr, input int gap);
        pbba_pkg::t_req req;
        req.op            = op;
        req.block_address = addr;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold until every outstanding response has been taken,
    // then give the block time to return to idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers on consecutive cycles; call only while idle.
    task automatic program_page(input logic [3:0] log2, input logic [31:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pbba_pkg::REG_BLOCK_SIZE_LOG2;
        i_cfg_data  <= {28'h0, log2};
        @(posedge i_clk);
        i_cfg_index <= pbba_pkg::REG_PAGE_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Response side: random stalls after each response, stretches of none,
    // and a long hold-off whenever the request side asks for one.
    initial begin : response_side
        int taken;
        int stall;
        int hold_served;
        bit steady;
        taken       = 0;
        stall       = 0;
        hold_served = 0;
        steady      = 1'b0;
        i_out_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (o_out_valid && i_out_ready) begin
                taken++;
                if (taken % 97 == 0) steady = ($urandom_range(0, 2) == 0);
                stall = idle_gap(steady);
            end
            if (hold_served != hold_asks) begin
                hold_served++;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin : request_side
        int         phase;
        int         k;
        int         items;
        int         alloc_pct;
        bit         steady;
        logic [3:0] log2;
        logic [31:0] base;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = pbba_pkg::REG_BLOCK_SIZE_LOG2;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 4-byte blocks at base 0, full 1024-block map.
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'hFFFF_FFFF, idle_gap(0));   // address ignored on allocate
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'h0000_0004, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));   // reuse the freed hole
        offer(pbba_pkg::OP_FREE,  32'h0000_0004, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'h0000_0004, idle_gap(0));   // double free
        offer(pbba_pkg::OP_FREE,  32'h0000_0005, idle_gap(0));   // inside a block
        offer(pbba_pkg::OP_FREE,  32'h0000_1000, idle_gap(0));   // first block past the page
        offer(pbba_pkg::OP_FREE,  32'hFFFF_FFFC, idle_gap(0));   // far beyond
        settle();

        // One 4 KiB block at the top of the address space: page fills at once.
        program_page(4'd12, 32'hFFFF_F000);
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));   // full
        offer(pbba_pkg::OP_FREE,  32'hFFFF_F000, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'h0000_0000, idle_gap(0));   // offset wraps past the page
        offer(pbba_pkg::OP_FREE,  32'hFFFF_F800, idle_gap(0));
        settle();

        // Largest shift, base at all ones.
        program_page(4'd15, 32'hFFFF_FFFF);
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'hFFFF_FFFF, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        settle();

        // One-byte blocks near the top: granted addresses wrap through zero.
        program_page(4'd0, 32'hFFFF_FFFE);
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'h0000_0000, idle_gap(0));
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));
        settle();

        program_page(4'd1, 32'h8000_0000);
        offer(pbba_pkg::OP_FREE,  32'h8000_0001, idle_gap(0));
        offer(pbba_pkg::OP_FREE,  32'h8000_0800, idle_gap(0));   // index equals block count
        offer(pbba_pkg::OP_ALLOC, 32'h0000_0000, idle_gap(0));

        // Random phases: each with its own page setting and allocate/free mix.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    log2 = 4'd13;
                    base = 32'hFFFF_FFFF;
                end
                1: begin
                    log2 = 4'd0;
                    base = 32'h0000_0000;
                end
                2: begin
                    log2 = 4'd12;
                    base = $urandom();
                end
                3: begin
                    log2 = 4'd15;
                    base = 32'h0000_0000;
                end
                default: begin
                    log2 = ($urandom_range(0, 3) != 0) ? $urandom_range(7, 15)
                                                       : $urandom_range(0, 6);
                    base = ($urandom_range(0, 1) != 0) ? $urandom()
                                                       : ($urandom() & 32'hFFFF_F000);
                end
            endcase
            settle();
            program_page(log2, base);

            items     = $urandom_range(100, 155);
            alloc_pct = (phase % 3 == 0) ? 90 : ((phase % 3 == 1) ? 70 : 50);
            steady    = (phase % 4 == 2);
            for (k = 0; k < items; k++) begin
                // Starve the response side while requests keep coming, so the
                // block backs up and stalls its input.
                if (k == 20 && (phase == 3 || phase == 8)) hold_asks <= hold_asks + 1;
                // Hold the request side until everything has drained.
                if (k == 60 && phase == 5) settle();
                if ($urandom_range(0, 99) < alloc_pct) begin
                    offer(pbba_pkg::OP_ALLOC, $urandom(), idle_gap(steady));
                end else begin
                    offer(pbba_pkg::OP_FREE, pick_free_address(log2, base), idle_gap(steady));
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
